FILE: rtl/core/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

    localparam int Rounds = 14;
    localparam int KeyWords = 4;
    localparam int KeyWordW = 64;
    localparam int CfgIdxW = 2;

    typedef logic [127:0] t_block;
    typedef logic [7:0] t_byte;

    // forward S-box
    function automatic t_byte sbox(input t_byte x);
        t_byte s;
        case (x)
            8'h00: s=8'h63; 8'h01: s=8'h7c; 8'h02: s=8'h77; 8'h03: s=8'h7b;
            8'h04: s=8'hf2; 8'h05: s=8'h6b; 8'h06: s=8'h6f; 8'h07: s=8'hc5;
            8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0a: s=8'h67; 8'h0b: s=8'h2b;
            8'h0c: s=8'hfe; 8'h0d: s=8'hd7; 8'h0e: s=8'hab; 8'h0f: s=8'h76;
            8'h10: s=8'hca; 8'h11: s=8'h82; 8'h12: s=8'hc9; 8'h13: s=8'h7d;
            8'h14: s=8'hfa; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hf0;
            8'h18: s=8'had; 8'h19: s=8'hd4; 8'h1a: s=8'ha2; 8'h1b: s=8'haf;
            8'h1c: s=8'h9c; 8'h1d: s=8'ha4; 8'h1e: s=8'h72; 8'h1f: s=8'hc0;
            8'h20: s=8'hb7; 8'h21: s=8'hfd; 8'h22: s=8'h93; 8'h23: s=8'h26;
            8'h24: s=8'h36; 8'h25: s=8'h3f; 8'h26: s=8'hf7; 8'h27: s=8'hcc;
            8'h28: s=8'h34; 8'h29: s=8'ha5; 8'h2a: s=8'he5; 8'h2b: s=8'hf1;
            8'h2c: s=8'h71; 8'h2d: s=8'hd8; 8'h2e: s=8'h31; 8'h2f: s=8'h15;
            8'h30: s=8'h04; 8'h31: s=8'hc7; 8'h32: s=8'h23; 8'h33: s=8'hc3;
            8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9a;
            8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3a: s=8'h80; 8'h3b: s=8'he2;
            8'h3c: s=8'heb; 8'h3d: s=8'h27; 8'h3e: s=8'hb2; 8'h3f: s=8'h75;
            8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2c; 8'h43: s=8'h1a;
            8'h44: s=8'h1b; 8'h45: s=8'h6e; 8'h46: s=8'h5a; 8'h47: s=8'ha0;
            8'h48: s=8'h52; 8'h49: s=8'h3b; 8'h4a: s=8'hd6; 8'h4b: s=8'hb3;
            8'h4c: s=8'h29; 8'h4d: s=8'he3; 8'h4e: s=8'h2f; 8'h4f: s=8'h84;
            8'h50: s=8'h53; 8'h51: s=8'hd1; 8'h52: s=8'h00; 8'h53: s=8'hed;
            8'h54: s=8'h20; 8'h55: s=8'hfc; 8'h56: s=8'hb1; 8'h57: s=8'h5b;
            8'h58: s=8'h6a; 8'h59: s=8'hcb; 8'h5a: s=8'hbe; 8'h5b: s=8'h39;
            8'h5c: s=8'h4a; 8'h5d: s=8'h4c; 8'h5e: s=8'h58; 8'h5f: s=8'hcf;
            8'h60: s=8'hd0; 8'h61: s=8'hef; 8'h62: s=8'haa; 8'h63: s=8'hfb;
            8'h64: s=8'h43; 8'h65: s=8'h4d; 8'h66: s=8'h33; 8'h67: s=8'h85;
            8'h68: s=8'h45; 8'h69: s=8'hf9; 8'h6a: s=8'h02; 8'h6b: s=8'h7f;
            8'h6c: s=8'h50; 8'h6d: s=8'h3c; 8'h6e: s=8'h9f; 8'h6f: s=8'ha8;
            8'h70: s=8'h51; 8'h71: s=8'ha3; 8'h72: s=8'h40; 8'h73: s=8'h8f;
            8'h74: s=8'h92; 8'h75: s=8'h9d; 8'h76: s=8'h38; 8'h77: s=8'hf5;
            8'h78: s=8'hbc; 8'h79: s=8'hb6; 8'h7a: s=8'hda; 8'h7b: s=8'h21;
            8'h7c: s=8'h10; 8'h7d: s=8'hff; 8'h7e: s=8'hf3; 8'h7f: s=8'hd2;
            8'h80: s=8'hcd; 8'h81: s=8'h0c; 8'h82: s=8'h13; 8'h83: s=8'hec;
            8'h84: s=8'h5f; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
            8'h88: s=8'hc4; 8'h89: s=8'ha7; 8'h8a: s=8'h7e; 8'h8b: s=8'h3d;
            8'h8c: s=8'h64; 8'h8d: s=8'h5d; 8'h8e: s=8'h19; 8'h8f: s=8'h73;
            8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4f; 8'h93: s=8'hdc;
            8'h94: s=8'h22; 8'h95: s=8'h2a; 8'h96: s=8'h90; 8'h97: s=8'h88;
            8'h98: s=8'h46; 8'h99: s=8'hee; 8'h9a: s=8'hb8; 8'h9b: s=8'h14;
            8'h9c: s=8'hde; 8'h9d: s=8'h5e; 8'h9e: s=8'h0b; 8'h9f: s=8'hdb;
            8'ha0: s=8'he0; 8'ha1: s=8'h32; 8'ha2: s=8'h3a; 8'ha3: s=8'h0a;
            8'ha4: s=8'h49; 8'ha5: s=8'h06; 8'ha6: s=8'h24; 8'ha7: s=8'h5c;
            8'ha8: s=8'hc2; 8'ha9: s=8'hd3; 8'haa: s=8'hac; 8'hab: s=8'h62;
            8'hac: s=8'h91; 8'had: s=8'h95; 8'hae: s=8'he4; 8'haf: s=8'h79;
            8'hb0: s=8'he7; 8'hb1: s=8'hc8; 8'hb2: s=8'h37; 8'hb3: s=8'h6d;
            8'hb4: s=8'h8d; 8'hb5: s=8'hd5; 8'hb6: s=8'h4e; 8'hb7: s=8'ha9;
            8'hb8: s=8'h6c; 8'hb9: s=8'h56; 8'hba: s=8'hf4; 8'hbb: s=8'hea;
            8'hbc: s=8'h65; 8'hbd: s=8'h7a; 8'hbe: s=8'hae; 8'hbf: s=8'h08;
            8'hc0: s=8'hba; 8'hc1: s=8'h78; 8'hc2: s=8'h25; 8'hc3: s=8'h2e;
            8'hc4: s=8'h1c; 8'hc5: s=8'ha6; 8'hc6: s=8'hb4; 8'hc7: s=8'hc6;
            8'hc8: s=8'he8; 8'hc9: s=8'hdd; 8'hca: s=8'h74; 8'hcb: s=8'h1f;
            8'hcc: s=8'h4b; 8'hcd: s=8'hbd; 8'hce: s=8'h8b; 8'hcf: s=8'h8a;
            8'hd0: s=8'h70; 8'hd1: s=8'h3e; 8'hd2: s=8'hb5; 8'hd3: s=8'h66;
            8'hd4: s=8'h48; 8'hd5: s=8'h03; 8'hd6: s=8'hf6; 8'hd7: s=8'h0e;
            8'hd8: s=8'h61; 8'hd9: s=8'h35; 8'hda: s=8'h57; 8'hdb: s=8'hb9;
            8'hdc: s=8'h86; 8'hdd: s=8'hc1; 8'hde: s=8'h1d; 8'hdf: s=8'h9e;
            8'he0: s=8'he1; 8'he1: s=8'hf8; 8'he2: s=8'h98; 8'he3: s=8'h11;
            8'he4: s=8'h69; 8'he5: s=8'hd9; 8'he6: s=8'h8e; 8'he7: s=8'h94;
            8'he8: s=8'h9b; 8'he9: s=8'h1e; 8'hea: s=8'h87; 8'heb: s=8'he9;
            8'hec: s=8'hce; 8'hed: s=8'h55; 8'hee: s=8'h28; 8'hef: s=8'hdf;
            8'hf0: s=8'h8c; 8'hf1: s=8'ha1; 8'hf2: s=8'h89; 8'hf3: s=8'h0d;
            8'hf4: s=8'hbf; 8'hf5: s=8'he6; 8'hf6: s=8'h42; 8'hf7: s=8'h68;
            8'hf8: s=8'h41; 8'hf9: s=8'h99; 8'hfa: s=8'h2d; 8'hfb: s=8'h0f;
            8'hfc: s=8'hb0; 8'hfd: s=8'h54; 8'hfe: s=8'hbb; 8'hff: s=8'h16;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // inverse S-box: 256-entry search is avoided by a direct table
    function automatic t_byte inv_sbox(input t_byte x);
        t_byte s;
        case (x)
            8'h00: s=8'h52; 8'h01: s=8'h09; 8'h02: s=8'h6a; 8'h03: s=8'hd5;
            8'h04: s=8'h30; 8'h05: s=8'h36; 8'h06: s=8'ha5; 8'h07: s=8'h38;
            8'h08: s=8'hbf; 8'h09: s=8'h40; 8'h0a: s=8'ha3; 8'h0b: s=8'h9e;
            8'h0c: s=8'h81; 8'h0d: s=8'hf3; 8'h0e: s=8'hd7; 8'h0f: s=8'hfb;
            8'h10: s=8'h7c; 8'h11: s=8'he3; 8'h12: s=8'h39; 8'h13: s=8'h82;
            8'h14: s=8'h9b; 8'h15: s=8'h2f; 8'h16: s=8'hff; 8'h17: s=8'h87;
            8'h18: s=8'h34; 8'h19: s=8'h8e; 8'h1a: s=8'h43; 8'h1b: s=8'h44;
            8'h1c: s=8'hc4; 8'h1d: s=8'hde; 8'h1e: s=8'he9; 8'h1f: s=8'hcb;
            8'h20: s=8'h54; 8'h21: s=8'h7b; 8'h22: s=8'h94; 8'h23: s=8'h32;
            8'h24: s=8'ha6; 8'h25: s=8'hc2; 8'h26: s=8'h23; 8'h27: s=8'h3d;
            8'h28: s=8'hee; 8'h29: s=8'h4c; 8'h2a: s=8'h95; 8'h2b: s=8'h0b;
            8'h2c: s=8'h42; 8'h2d: s=8'hfa; 8'h2e: s=8'hc3; 8'h2f: s=8'h4e;
            8'h30: s=8'h08; 8'h31: s=8'h2e; 8'h32: s=8'ha1; 8'h33: s=8'h66;
            8'h34: s=8'h28; 8'h35: s=8'hd9; 8'h36: s=8'h24; 8'h37: s=8'hb2;
            8'h38: s=8'h76; 8'h39: s=8'h5b; 8'h3a: s=8'ha2; 8'h3b: s=8'h49;
            8'h3c: s=8'h6d; 8'h3d: s=8'h8b; 8'h3e: s=8'hd1; 8'h3f: s=8'h25;
            8'h40: s=8'h72; 8'h41: s=8'hf8; 8'h42: s=8'hf6; 8'h43: s=8'h64;
            8'h44: s=8'h86; 8'h45: s=8'h68; 8'h46: s=8'h98; 8'h47: s=8'h16;
            8'h48: s=8'hd4; 8'h49: s=8'ha4; 8'h4a: s=8'h5c; 8'h4b: s=8'hcc;
            8'h4c: s=8'h5d; 8'h4d: s=8'h65; 8'h4e: s=8'hb6; 8'h4f: s=8'h92;
            8'h50: s=8'h6c; 8'h51: s=8'h70; 8'h52: s=8'h48; 8'h53: s=8'h50;
            8'h54: s=8'hfd; 8'h55: s=8'hed; 8'h56: s=8'hb9; 8'h57: s=8'hda;
            8'h58: s=8'h5e; 8'h59: s=8'h15; 8'h5a: s=8'h46; 8'h5b: s=8'h57;
            8'h5c: s=8'ha7; 8'h5d: s=8'h8d; 8'h5e: s=8'h9d; 8'h5f: s=8'h84;
            8'h60: s=8'h90; 8'h61: s=8'hd8; 8'h62: s=8'hab; 8'h63: s=8'h00;
            8'h64: s=8'h8c; 8'h65: s=8'hbc; 8'h66: s=8'hd3; 8'h67: s=8'h0a;
            8'h68: s=8'hf7; 8'h69: s=8'he4; 8'h6a: s=8'h58; 8'h6b: s=8'h05;
            8'h6c: s=8'hb8; 8'h6d: s=8'hb3; 8'h6e: s=8'h45; 8'h6f: s=8'h06;
            8'h70: s=8'hd0; 8'h71: s=8'h2c; 8'h72: s=8'h1e; 8'h73: s=8'h8f;
            8'h74: s=8'hca; 8'h75: s=8'h3f; 8'h76: s=8'h0f; 8'h77: s=8'h02;
            8'h78: s=8'hc1; 8'h79: s=8'haf; 8'h7a: s=8'hbd; 8'h7b: s=8'h03;
            8'h7c: s=8'h01; 8'h7d: s=8'h13; 8'h7e: s=8'h8a; 8'h7f: s=8'h6b;
            8'h80: s=8'h3a; 8'h81: s=8'h91; 8'h82: s=8'h11; 8'h83: s=8'h41;
            8'h84: s=8'h4f; 8'h85: s=8'h67; 8'h86: s=8'hdc; 8'h87: s=8'hea;
            8'h88: s=8'h97; 8'h89: s=8'hf2; 8'h8a: s=8'hcf; 8'h8b: s=8'hce;
            8'h8c: s=8'hf0; 8'h8d: s=8'hb4; 8'h8e: s=8'he6; 8'h8f: s=8'h73;
            8'h90: s=8'h96; 8'h91: s=8'hac; 8'h92: s=8'h74; 8'h93: s=8'h22;
            8'h94: s=8'he7; 8'h95: s=8'had; 8'h96: s=8'h35; 8'h97: s=8'h85;
            8'h98: s=8'he2; 8'h99: s=8'hf9; 8'h9a: s=8'h37; 8'h9b: s=8'he8;
            8'h9c: s=8'h1c; 8'h9d: s=8'h75; 8'h9e: s=8'hdf; 8'h9f: s=8'h6e;
            8'ha0: s=8'h47; 8'ha1: s=8'hf1; 8'ha2: s=8'h1a; 8'ha3: s=8'h71;
            8'ha4: s=8'h1d; 8'ha5: s=8'h29; 8'ha6: s=8'hc5; 8'ha7: s=8'h89;
            8'ha8: s=8'h6f; 8'ha9: s=8'hb7; 8'haa: s=8'h62; 8'hab: s=8'h0e;
            8'hac: s=8'haa; 8'had: s=8'h18; 8'hae: s=8'hbe; 8'haf: s=8'h1b;
            8'hb0: s=8'hfc; 8'hb1: s=8'h56; 8'hb2: s=8'h3e; 8'hb3: s=8'h4b;
            8'hb4: s=8'hc6; 8'hb5: s=8'hd2; 8'hb6: s=8'h79; 8'hb7: s=8'h20;
            8'hb8: s=8'h9a; 8'hb9: s=8'hdb; 8'hba: s=8'hc0; 8'hbb: s=8'hfe;
            8'hbc: s=8'h78; 8'hbd: s=8'hcd; 8'hbe: s=8'h5a; 8'hbf: s=8'hf4;
            8'hc0: s=8'h1f; 8'hc1: s=8'hdd; 8'hc2: s=8'ha8; 8'hc3: s=8'h33;
            8'hc4: s=8'h88; 8'hc5: s=8'h07; 8'hc6: s=8'hc7; 8'hc7: s=8'h31;
            8'hc8: s=8'hb1; 8'hc9: s=8'h12; 8'hca: s=8'h10; 8'hcb: s=8'h59;
            8'hcc: s=8'h27; 8'hcd: s=8'h80; 8'hce: s=8'hec; 8'hcf: s=8'h5f;
            8'hd0: s=8'h60; 8'hd1: s=8'h51; 8'hd2: s=8'h7f; 8'hd3: s=8'ha9;
            8'hd4: s=8'h19; 8'hd5: s=8'hb5; 8'hd6: s=8'h4a; 8'hd7: s=8'h0d;
            8'hd8: s=8'h2d; 8'hd9: s=8'he5; 8'hda: s=8'h7a; 8'hdb: s=8'h9f;
            8'hdc: s=8'h93; 8'hdd: s=8'hc9; 8'hde: s=8'h9c; 8'hdf: s=8'hef;
            8'he0: s=8'ha0; 8'he1: s=8'he0; 8'he2: s=8'h3b; 8'he3: s=8'h4d;
            8'he4: s=8'hae; 8'he5: s=8'h2a; 8'he6: s=8'hf5; 8'he7: s=8'hb0;
            8'he8: s=8'hc8; 8'he9: s=8'heb; 8'hea: s=8'hbb; 8'heb: s=8'h3c;
            8'hec: s=8'h83; 8'hed: s=8'h53; 8'hee: s=8'h99; 8'hef: s=8'h61;
            8'hf0: s=8'h17; 8'hf1: s=8'h2b; 8'hf2: s=8'h04; 8'hf3: s=8'h7e;
            8'hf4: s=8'hba; 8'hf5: s=8'h77; 8'hf6: s=8'hd6; 8'hf7: s=8'h26;
            8'hf8: s=8'he1; 8'hf9: s=8'h69; 8'hfa: s=8'h14; 8'hfb: s=8'h63;
            8'hfc: s=8'h55; 8'hfd: s=8'h21; 8'hfe: s=8'h0c; 8'hff: s=8'h7d;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic t_byte get_b(input t_block s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic t_byte xt(input t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // one round; forward: sub/shift/mix/key, inverse: sub/shift/key/mix; mix is skipped when last
    function automatic t_block do_round(input t_block s, input t_block k,
                                        input logic inv, input logic last);
        t_block t;
        t_block m;
        t_byte a0, a1, a2, a3, e, b, d;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv)
                    t[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = inv_sbox(get_b(s, c * 4 + r));
                else
                    t[127 - 8 * (c * 4 + r) -: 8] = sbox(get_b(s, ((c + r) % 4) * 4 + r));
            end
        end
        if (inv) t = t ^ k;
        m = t;
        for (int c = 0; c < 4; c++) begin
            a0 = get_b(t, c * 4);
            a1 = get_b(t, c * 4 + 1);
            a2 = get_b(t, c * 4 + 2);
            a3 = get_b(t, c * 4 + 3);
            if (inv) begin
                // pre-step turns inverse mix into forward mix
                e = xt(xt(a0 ^ a2));
                d = xt(xt(a1 ^ a3));
                a0 = a0 ^ e; a2 = a2 ^ e;
                a1 = a1 ^ d; a3 = a3 ^ d;
            end
            b = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 8 * (c * 4) -: 8]     = a0 ^ b ^ xt(a0 ^ a1);
            m[127 - 8 * (c * 4 + 1) -: 8] = a1 ^ b ^ xt(a1 ^ a2);
            m[127 - 8 * (c * 4 + 2) -: 8] = a2 ^ b ^ xt(a2 ^ a3);
            m[127 - 8 * (c * 4 + 3) -: 8] = a3 ^ b ^ xt(a3 ^ a0);
        end
        if (!last) t = m;
        if (!inv) t = t ^ k;
        return t;
    endfunction

endpackage

FILE: rtl/core/aes_key_exp.sv
`timescale 1ns / 1ps
// Key schedule from the held key, one word group per round key; the user must keep the
// key stable while blocks run (this block does not enforce it), and the schedule is
// recomputed through registers after each write.
module aes_key_exp (
    input  logic                      i_clk,
    input  logic [4*64-1:0]           i_key,
    output logic [15*128-1:0]         o_rk
);
    logic [31:0] r_w [0:59];
    logic [31:0] n_w [0:59];
    logic [31:0] t;
    logic [7:0]  rc;

    // one registered step per expanded word: each word is registered from earlier registered
    // words, so the schedule ripples through the words in order after the key changes
    always_comb begin
        t  = '0;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) n_w[i] = i_key[255 - 32 * i -: 32];
        for (int i = 8; i < 60; i++) begin
            t = r_w[i - 1];
            if (i % 8 == 0) begin
                t = {aes_pkg::sbox(t[23:16]), aes_pkg::sbox(t[15:8]),
                     aes_pkg::sbox(t[7:0]), aes_pkg::sbox(t[31:24])};
                t[31:24] = t[31:24] ^ rc;
                rc = aes_pkg::xt(rc);
            end else if (i % 8 == 4) begin
                t = {aes_pkg::sbox(t[31:24]), aes_pkg::sbox(t[23:16]),
                     aes_pkg::sbox(t[15:8]), aes_pkg::sbox(t[7:0])};
            end
            n_w[i] = r_w[i - 8] ^ t;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 60; i++) r_w[i] <= n_w[i];
    end

    always_comb begin
        for (int i = 0; i < 60; i++) o_rk[1919 - 32 * i -: 32] = r_w[i];
    end
endmodule

FILE: rtl/core/aes256_block_cipher_core.sv
`timescale 1ns / 1ps
// Stages: initial key add, 14 rounds, output register.
// Throughput: one block per cycle unless stalled or held off; each round is one pipeline stage.
// Stalls: the whole pipe holds while a result waits on m_axis_tready.
// Key schedule ripples after a key write or reset; requests are held off until it settles.
// Reset: i_rst_n synchronous active low clears stage valid bits and key registers.
module aes256_block_cipher_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_hi [63:0], block_lo [127:64]
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_hi [63:0], result_lo [127:64]
    input  logic         i_cfg_we,
    input  logic [aes_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [aes_pkg::KeyWordW-1:0] i_cfg_data
);
    localparam int N = aes_pkg::Rounds + 1;
    // cycles until the last expanded word is valid after a key change
    localparam int KeySettle = 4 * N - 7;

    logic [63:0]   r_key [0:3];
    logic [255:0]  key;
    logic [1919:0] rk;
    logic          adv;
    logic          take;
    logic [127:0]  blk_in;
    logic [5:0]    r_settle;
    logic          r_v [0:N];
    logic          r_d [0:N];
    logic [127:0]  r_s [0:N];

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end
    assign key = {r_key[0], r_key[1], r_key[2], r_key[3]};

    aes_key_exp u_kx (.i_clk(i_clk), .i_key(key), .o_rk(rk));

    // hold off requests while the key schedule ripples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= 6'(KeySettle);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 6'd1;
        end
    end

    // whole pipe stalls together when the output is held
    assign adv = !r_v[N] || m_axis_tready;
    assign s_axis_tready = adv && (r_settle == '0);
    assign take = s_axis_tvalid && s_axis_tready;

    // byte 0 sits at the top of the internal state
    assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= N; i++) r_v[i] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= take;
            for (int i = 1; i <= N; i++) r_v[i] <= r_v[i - 1];
        end
    end

    // stage 0: initial key add; stages 1..14: rounds; stage 15: output
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d[0] <= s_axis_tuser;
            r_s[0] <= blk_in ^ (s_axis_tuser ? rk[127:0] : rk[1919 -: 128]);
            for (int i = 1; i <= N; i++) r_d[i] <= r_d[i - 1];
            for (int i = 1; i < N; i++) begin
                r_s[i] <= aes_pkg::do_round(r_s[i - 1],
                    r_d[i - 1] ? rk[1919 - 128 * (N - 1 - i) -: 128]
                               : rk[1919 - 128 * i -: 128],
                    r_d[i - 1], i == N - 1);
            end
            r_s[N] <= r_s[N - 1];
        end
    end

    assign m_axis_tvalid = r_v[N];
    assign m_axis_tdata  = {r_s[N][63:0], r_s[N][127:64]};

    // output must hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    // a valid stage 0 moves on to stage 1 when the pipe advances
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && adv |=> r_v[1])
        else $error("valid lost in pipe");
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam logic [aes_pkg::CfgIdxW-1:0] REG_KEY0 = 2'd0;
    localparam logic [aes_pkg::CfgIdxW-1:0] REG_KEY1 = 2'd1;
    localparam logic [aes_pkg::CfgIdxW-1:0] REG_KEY2 = 2'd2;
    localparam logic [aes_pkg::CfgIdxW-1:0] REG_KEY3 = 2'd3;
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    // expected cipher outputs, in request order
    class cipher_scoreboard;
        aes_pkg::t_block pending[$];
        int errors;
        int checked;

        function void note_request(aes_pkg::t_block expected);
            pending = {pending, expected};
        endfunction

        function void check_result(aes_pkg::t_block got);
            aes_pkg::t_block want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got[127:64] !== want[127:64] || got[63:0] !== want[63:0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: hi exp %h got %h, lo exp %h got %h",
                             checked, want[127:64], got[127:64], want[63:0], got[63:0]);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // block_hi [63:0], block_lo [127:64]
    logic         s_axis_tuser;   // action
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // result_hi [63:0], result_lo [127:64]
    logic         i_cfg_we;
    logic [aes_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [aes_pkg::KeyWordW-1:0] i_cfg_data;

    aes256_block_cipher_core u_dut (.*);

    cipher_scoreboard sb;
    logic [7:0] fwd_tab[256];
    logic [7:0] inv_tab[256];
    logic [7:0] round_key[240];
    logic [63:0] key_reg[aes_pkg::KeyWords];
    logic   calm;
    aes_pkg::t_block last_cipher;
    int     cycles;
    int     n_enc, n_dec, n_keys;

    // bus word (hi in low half) to block with byte 0 on top, and back
    function automatic aes_pkg::t_block swap_halves(input logic [127:0] w);
        return {w[63:0], w[127:64]};
    endfunction

    // GF(2^8) arithmetic for the predictor
    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    // S-boxes from the inverse in GF(2^8) plus the affine map
    task automatic build_tables();
        logic [7:0] v, s;
        for (int x = 0; x < 256; x++) begin
            v = (x == 0) ? 8'h00 : 8'h01;
            if (x != 0) for (int k = 0; k < 254; k++) v = gf_mul(v, x[7:0]);
            s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = x[7:0];
        end
    endtask

    // key expansion for the current key registers
    task automatic expand_key();
        logic [7:0] t[4];
        logic [7:0] u, rc;
        rc = 8'h01;
        for (int i = 0; i < 32; i++) round_key[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = 8; i < 60; i++) begin
            for (int j = 0; j < 4; j++) t[j] = round_key[(i - 1) * 4 + j];
            if (i % 8 == 0) begin
                u = t[0];
                t[0] = fwd_tab[t[1]] ^ rc;
                t[1] = fwd_tab[t[2]];
                t[2] = fwd_tab[t[3]];
                t[3] = fwd_tab[u];
                rc = gf_dbl(rc);
            end else if (i % 8 == 4) begin
                for (int j = 0; j < 4; j++) t[j] = fwd_tab[t[j]];
            end
            for (int j = 0; j < 4; j++) round_key[i * 4 + j] = round_key[(i - 8) * 4 + j] ^ t[j];
        end
    endtask

    function automatic aes_pkg::t_block aes_predict(input aes_pkg::t_block blk,
                                                    input logic act);
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] col[4];
        logic [7:0] fm[4];
        logic [7:0] im[4];
        logic [7:0] acc;
        logic       dec;
        int         rnd;
        aes_pkg::t_block res;
        fm = '{8'h02, 8'h03, 8'h01, 8'h01};
        im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        dec = (act == ACT_DECRYPT);
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
        for (int step = 0; step <= aes_pkg::Rounds; step++) begin
            rnd = dec ? aes_pkg::Rounds - step : step;
            if (step > 0) begin
                // byte substitution and row shift
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        if (dec) t[((c + r) % 4) * 4 + r] = inv_tab[s[c * 4 + r]];
                        else     t[c * 4 + r] = fwd_tab[s[((c + r) % 4) * 4 + r]];
                s = t;
                // forward mixes before the key, inverse after
                if (!dec && step < aes_pkg::Rounds) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int k = 0; k < 4; k++) col[k] = s[c * 4 + k];
                        for (int r = 0; r < 4; r++) begin
                            acc = 8'h00;
                            for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], fm[(k - r + 4) % 4]);
                            s[c * 4 + r] = acc;
                        end
                    end
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= round_key[rnd * 16 + i];
            if (dec && step > 0 && step < aes_pkg::Rounds) begin
                for (int c = 0; c < 4; c++) begin
                    for (int k = 0; k < 4; k++) col[k] = s[c * 4 + k];
                    for (int r = 0; r < 4; r++) begin
                        acc = 8'h00;
                        for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], im[(k - r + 4) % 4]);
                        s[c * 4 + r] = acc;
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // accepted requests feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(aes_predict(swap_halves(s_axis_tdata), s_axis_tuser));
            if (s_axis_tuser == ACT_DECRYPT) n_dec++;
            else n_enc++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(swap_halves(m_axis_tdata));
            last_cipher <= swap_halves(m_axis_tdata);
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 10);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_block(input logic act, input aes_pkg::t_block blk);
        if (!calm) begin
            while ($urandom_range(99) < 10) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= swap_halves(blk);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // key load only with the pipeline empty; the block holds off requests
    // until its schedule has settled
    task automatic load_key(input logic [63:0] k0, k1, k2, k3);
        logic [63:0] kv[4];
        kv = '{k0, k1, k2, k3};
        drain();
        repeat (20) @(posedge i_clk);
        for (int i = 0; i < aes_pkg::KeyWords; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[aes_pkg::CfgIdxW-1:0];
            i_cfg_data <= kv[i];
            @(posedge i_clk);
            key_reg[i] = kv[i];
        end
        i_cfg_we <= 1'b0;
        expand_key();
        n_keys++;
        repeat (12) @(posedge i_clk);
    endtask

    function automatic aes_pkg::t_block rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic random_run(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                // hold off until the pipeline is empty
                drain();
                repeat ($urandom_range(5, 1)) @(posedge i_clk);
            end
            // half fresh encryptions, a quarter decrypts of the last result, a quarter raw decrypts
            case ($urandom_range(3))
                0: send_block(ACT_DECRYPT, last_cipher);
                1: send_block(ACT_DECRYPT, rand_block());
                default: send_block(ACT_ENCRYPT, rand_block());
            endcase
        end
    endtask

    initial begin
        sb = new;
        calm = 1'b0;
        cycles = 0;
        n_enc = 0;
        n_dec = 0;
        n_keys = 0;
        last_cipher = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_ENCRYPT;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_KEY0;
        i_cfg_data = '0;
        build_tables();
        for (int i = 0; i < aes_pkg::KeyWords; i++) key_reg[i] = '0;
        expand_key();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        // directed: reset key, extreme blocks, both actions
        send_block(ACT_ENCRYPT, '0);
        send_block(ACT_ENCRYPT, '1);
        send_block(ACT_DECRYPT, '0);
        send_block(ACT_DECRYPT, '1);
        send_block(ACT_ENCRYPT, {64'h8000_0000_0000_0000, 64'h1});
        // standard AES-256 vector key and its plaintext
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(ACT_ENCRYPT, 128'h00112233445566778899aabbccddeeff);
        send_block(ACT_DECRYPT, 128'h8ea2b7ca516745bfeafc49904b496089);
        send_block(ACT_ENCRYPT, '1);
        send_block(ACT_DECRYPT, '0);
        // all-ones key
        load_key('1, '1, '1, '1);
        send_block(ACT_ENCRYPT, '0);
        send_block(ACT_ENCRYPT, '1);
        send_block(ACT_DECRYPT, '1);
        send_block(ACT_DECRYPT, '0);
        // a single word changed from the all-ones key
        load_key('1, '1, '0, '1);
        send_block(ACT_ENCRYPT, 128'h00112233445566778899aabbccddeeff);
        send_block(ACT_DECRYPT, 128'h00112233445566778899aabbccddeeff);

        // random blocks under random keys, one run with no idling
        for (int ph = 0; ph < 6; ph++) begin
            load_key({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            calm = (ph == 2);
            random_run(300);
        end
        calm = 1'b0;
        load_key('0, '0, '0, '0);
        random_run(20);

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d encrypt and %0d decrypt requests under %0d key loads",
                 n_enc, n_dec, n_keys);
        $display("%0d results checked, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
